// File: design/ffa_pkg.sv
`default_nettype none

package ffa_pkg;

  // Default depth of the frame table.
  localparam int NUM_FRAMES_DEF = 1024;

  // Fixed field widths of the request, result and configuration ports.
  localparam int RT_W      = 2;
  localparam int PC_W      = 11;
  localparam int FI_W      = 10;
  localparam int GF_W      = 10;
  localparam int ST_W      = 2;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Request types.
  localparam logic [RT_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [RT_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [RT_W-1:0] REQ_INIT  = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [ST_W-1:0] STAT_NOSPACE  = 2'd1;
  localparam logic [ST_W-1:0] STAT_INACTIVE = 2'd2;
  localparam logic [ST_W-1:0] STAT_RANGE    = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 1'd1;
  localparam logic [CFG_W-1:0]     FRAME_COUNT_RST = 11'd1024;
  localparam logic [CFG_W-1:0]     RESERVED_RST    = 11'd0;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT,
    S_SCAN,
    S_MARK,
    S_FREE_LEN,
    S_RELEASE,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            req_load;
    logic            init_start;
    logic            init_step;
    logic            scan_start;
    logic            scan_step;
    logic            mark_step;
    logic            rel_setup;
    logic            rel_step;
    logic            pend_load;
    logic            pend_hit;
    logic [ST_W-1:0] pend_status;
    logic            resp_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            active;
    logic [RT_W-1:0] req;
    logic            out_of_range;
    logic            scan_hit;
    logic            scan_miss;
    logic            ptr_done;
    logic            init_last;
  } stat_t;

endpackage

`default_nettype wire

// File: design/first_fit_frame_allocator.sv
`default_nettype none

// First-fit frame allocator. Each request (allocate, free or init) gives one
// result transaction. The frame table lives in two memories, each with one
// write and one registered read per cycle, that are walked one entry per
// cycle: init sweeps the whole table, allocate scans up to the managed frame
// count and then marks the granted run, free marks the released run, and a
// request before init or an out-of-range free walks nothing. The tables are
// undefined after reset; init is the pass that writes every entry, and every
// request before it answers inactive. One request is worked at a time; a new
// one is taken while the previous result still waits at the output.
// Register writes take effect at the next init.
module first_fit_frame_allocator #(
  parameter int NUM_FRAMES = ffa_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ffa_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ffa_pkg::RT_W-1:0]      in_req_type,
  input  wire logic [ffa_pkg::PC_W-1:0]      in_page_count,
  input  wire logic [ffa_pkg::FI_W-1:0]      in_frame_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ffa_pkg::GF_W-1:0]           out_granted_frame,
  output logic [ffa_pkg::ST_W-1:0]           out_status
);
  import ffa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Frame table and request registers.
  ffa_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_req_type       (in_req_type),
    .in_page_count     (in_page_count),
    .in_frame_index    (in_frame_index),
    .cmd               (cmd),
    .stat              (stat),
    .out_granted_frame (out_granted_frame),
    .out_status        (out_status)
  );

  // An accepted request keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input not stalled after an accepted transaction");

  // A new result is loaded only from the response state.
  a_result_from_resp: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)
  ) else $error("result appeared without a finished request");

  // Only a granted allocation carries a nonzero frame.
  a_grant_only_done: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_DONE) |-> (out_granted_frame == '0)
  ) else $error("nonzero granted frame on a failed request");

  // At most one table walk is commanded at a time.
  a_one_walk: assert property (
    @(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.init_step, cmd.scan_step, cmd.mark_step, cmd.rel_setup, cmd.rel_step})
  ) else $error("overlapping table walk commands");

endmodule

`default_nettype wire

// File: design/ffa_ctrl.sv
`default_nettype none

module ffa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          out_stall,
  output logic               out_valid,
  output ffa_pkg::cmd_t      cmd,
  input  wire ffa_pkg::stat_t stat
);
  import ffa_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.req == REQ_INIT) begin
          state_nxt = S_INIT;
        end else if (!stat.active) begin
          state_nxt = S_RESP;
        end else if (stat.req == REQ_ALLOC) begin
          state_nxt = S_SCAN;
        end else if (stat.req == REQ_FREE && !stat.out_of_range) begin
          state_nxt = S_FREE_LEN;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_INIT: begin
        if (stat.init_last) state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = S_MARK;
        end else if (stat.scan_miss) begin
          state_nxt = S_RESP;
        end
      end
      S_MARK: begin
        if (stat.ptr_done) state_nxt = S_RESP;
      end
      S_FREE_LEN: begin
        state_nxt = S_RELEASE;
      end
      S_RELEASE: begin
        if (stat.ptr_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.req_load = in_valid;
      end
      S_DISPATCH: begin
        if (stat.req == REQ_INIT) begin
          cmd.init_start = 1'b1;
        end else if (!stat.active) begin
          cmd.pend_load   = 1'b1;
          cmd.pend_status = STAT_INACTIVE;
        end else if (stat.req == REQ_ALLOC) begin
          cmd.scan_start = 1'b1;
        end else if (stat.req == REQ_FREE) begin
          cmd.pend_load = 1'b1;
          if (stat.out_of_range) begin
            cmd.pend_status = STAT_RANGE;
          end else begin
            cmd.pend_status = STAT_DONE;
          end
        end else begin
          cmd.pend_load   = 1'b1;
          cmd.pend_status = STAT_DONE;
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) begin
          cmd.pend_load   = 1'b1;
          cmd.pend_status = STAT_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.pend_load   = 1'b1;
          cmd.pend_hit    = 1'b1;
          cmd.pend_status = STAT_DONE;
        end else if (stat.scan_miss) begin
          cmd.pend_load   = 1'b1;
          cmd.pend_status = STAT_NOSPACE;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
      end
      S_FREE_LEN: begin
        cmd.rel_setup = 1'b1;
      end
      S_RELEASE: begin
        cmd.rel_step = 1'b1;
      end
      S_RESP: begin
        cmd.resp_load = !out_valid_r || !out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The result register stays valid until the transaction is taken.
  assign out_valid_nxt = cmd.resp_load | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/ffa_datapath.sv
`default_nettype none

module ffa_datapath #(
  parameter int NUM_FRAMES = ffa_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ffa_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic [ffa_pkg::RT_W-1:0]        in_req_type,
  input  wire logic [ffa_pkg::PC_W-1:0]        in_page_count,
  input  wire logic [ffa_pkg::FI_W-1:0]        in_frame_index,
  input  wire ffa_pkg::cmd_t                   cmd,
  output ffa_pkg::stat_t                       stat,
  output logic [ffa_pkg::GF_W-1:0]             out_granted_frame,
  output logic [ffa_pkg::ST_W-1:0]             out_status
);
  import ffa_pkg::*;

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int SUM_W = ((CNT_W > PC_W) ? CNT_W : PC_W) + 1;

  // Frame table: free map and run lengths, one port each way.
  logic            fmap_mem [NUM_FRAMES];
  logic [PC_W-1:0] rl_mem   [NUM_FRAMES];

  logic [CFG_W-1:0] frame_count_r, frame_count_nxt;
  logic [CFG_W-1:0] reserved_r, reserved_nxt;
  logic             active_r, active_nxt;
  logic [CNT_W-1:0] managed_r, managed_nxt;
  logic [CNT_W-1:0] res_r, res_nxt;
  logic [RT_W-1:0]  req_r, req_nxt;
  logic [PC_W-1:0]  need_r, need_nxt;
  logic [FI_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [PC_W-1:0]  len_r, len_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [ST_W-1:0]  pend_status_r, pend_status_nxt;
  logic [GF_W-1:0]  pend_grant_r, pend_grant_nxt;
  logic [GF_W-1:0]  out_grant_r, out_grant_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic             free_rd_r;
  logic [PC_W-1:0]  rl_rd_r;

  logic             fw_en;
  logic [IDX_W-1:0] fw_addr;
  logic             fw_data;
  logic             rw_en;
  logic [IDX_W-1:0] rw_addr;
  logic [PC_W-1:0]  rw_data;
  logic [IDX_W-1:0] rl_rd_addr;

  logic [CNT_W-1:0] cnt_clamp;
  logic [CNT_W-1:0] res_clamp;
  logic [PC_W:0]    len_inc;
  logic             hit_raw;
  logic             hit_now;
  logic [IDX_W-1:0] hit_start;
  logic             issue;
  logic             init_last;
  logic [SUM_W-1:0] rel_sum;
  logic [CNT_W-1:0] rel_end;

  // Configuration register writes.
  always_comb begin
    frame_count_nxt = frame_count_r;
    reserved_nxt    = reserved_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_COUNT: frame_count_nxt = cfg_data;
        CFG_RESERVED:    reserved_nxt    = cfg_data;
        default:         frame_count_nxt = frame_count_r;
      endcase
    end
  end

  // Managed count and reserved count clamped for init.
  always_comb begin
    if (SUM_W'(frame_count_r) > SUM_W'(NUM_FRAMES)) begin
      cnt_clamp = CNT_W'(NUM_FRAMES);
    end else begin
      cnt_clamp = CNT_W'(frame_count_r);
    end
    if (SUM_W'(reserved_r) > SUM_W'(cnt_clamp)) begin
      res_clamp = cnt_clamp;
    end else begin
      res_clamp = CNT_W'(reserved_r);
    end
  end

  // Scan check on the registered free bit read in the cycle before.
  assign len_inc   = (PC_W + 1)'(len_r) + (PC_W + 1)'(1);
  assign hit_raw   = chk_vld_r && free_rd_r && (len_inc >= (PC_W + 1)'(need_r));
  assign hit_now   = cmd.scan_step && hit_raw;
  assign hit_start = (len_r == '0) ? chk_idx_r : start_r;
  assign issue     = (ptr_r < managed_r);
  assign init_last = (ptr_r == CNT_W'(NUM_FRAMES - 1));

  // End of a released run, cut at the managed count.
  assign rel_sum = SUM_W'(idx_r) + SUM_W'(rl_rd_r);
  assign rel_end = (rel_sum > SUM_W'(managed_r)) ? managed_r : CNT_W'(rel_sum);

  // Sequencing of the table walks and memory write ports.
  always_comb begin
    active_nxt      = active_r;
    managed_nxt     = managed_r;
    res_nxt         = res_r;
    req_nxt         = req_r;
    need_nxt        = need_r;
    idx_nxt         = idx_r;
    ptr_nxt         = ptr_r;
    end_nxt         = end_r;
    start_nxt       = start_r;
    len_nxt         = len_r;
    chk_vld_nxt     = chk_vld_r;
    chk_idx_nxt     = chk_idx_r;
    pend_status_nxt = pend_status_r;
    pend_grant_nxt  = pend_grant_r;
    out_grant_nxt   = out_grant_r;
    out_status_nxt  = out_status_r;
    fw_en           = 1'b0;
    fw_addr         = ptr_r[IDX_W-1:0];
    fw_data         = 1'b0;
    rw_en           = 1'b0;
    rw_addr         = ptr_r[IDX_W-1:0];
    rw_data         = '0;

    if (cmd.req_load) begin
      req_nxt  = in_req_type;
      need_nxt = in_page_count;
      idx_nxt  = in_frame_index;
    end

    if (cmd.init_start) begin
      managed_nxt = cnt_clamp;
      res_nxt     = res_clamp;
      ptr_nxt     = '0;
    end

    // Init sweep writes one entry of both tables per cycle.
    if (cmd.init_step) begin
      fw_en   = 1'b1;
      fw_data = (ptr_r >= res_r) && (ptr_r < managed_r);
      rw_en   = 1'b1;
      rw_data = (ptr_r < res_r) ? PC_W'(1) : '0;
      ptr_nxt = ptr_r + CNT_W'(1);
      if (init_last) active_nxt = 1'b1;
    end

    if (cmd.scan_start) begin
      ptr_nxt     = '0;
      chk_vld_nxt = 1'b0;
      len_nxt     = '0;
    end

    // First-fit scan: issue a read, check the previous one.
    if (cmd.scan_step) begin
      if (issue) begin
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = ptr_r[IDX_W-1:0];
        ptr_nxt     = ptr_r + CNT_W'(1);
      end else begin
        chk_vld_nxt = 1'b0;
      end
      if (chk_vld_r) begin
        if (free_rd_r) begin
          start_nxt = hit_start;
          len_nxt   = len_inc[PC_W-1:0];
        end else begin
          len_nxt = '0;
        end
      end
      if (hit_now) begin
        start_nxt   = hit_start;
        chk_vld_nxt = 1'b0;
        ptr_nxt     = CNT_W'(hit_start);
        if (need_r == '0) begin
          end_nxt = CNT_W'(hit_start);
        end else begin
          end_nxt = CNT_W'(chk_idx_r) + CNT_W'(1);
        end
        rw_en   = 1'b1;
        rw_addr = hit_start;
        rw_data = need_r;
      end
    end

    // Mark the granted run used.
    if (cmd.mark_step && (ptr_r < end_r)) begin
      fw_en   = 1'b1;
      fw_data = 1'b0;
      ptr_nxt = ptr_r + CNT_W'(1);
    end

    if (cmd.rel_setup) begin
      ptr_nxt = CNT_W'(idx_r);
      end_nxt = rel_end;
    end

    // Mark the released run free.
    if (cmd.rel_step && (ptr_r < end_r)) begin
      fw_en   = 1'b1;
      fw_data = 1'b1;
      ptr_nxt = ptr_r + CNT_W'(1);
    end

    if (cmd.pend_load) begin
      pend_status_nxt = cmd.pend_status;
      pend_grant_nxt  = cmd.pend_hit ? GF_W'(hit_start) : '0;
    end

    if (cmd.resp_load) begin
      out_grant_nxt  = pend_grant_r;
      out_status_nxt = pend_status_r;
    end
  end

  assign rl_rd_addr = IDX_W'(idx_r);

  // Free map: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (fw_en) fmap_mem[fw_addr] <= fw_data;
    free_rd_r <= fmap_mem[ptr_r[IDX_W-1:0]];
  end

  // Run-length table: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (rw_en) rl_mem[rw_addr] <= rw_data;
    rl_rd_r <= rl_mem[rl_rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      reserved_r    <= RESERVED_RST;
      active_r      <= 1'b0;
    end else begin
      frame_count_r <= frame_count_nxt;
      reserved_r    <= reserved_nxt;
      active_r      <= active_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    managed_r     <= managed_nxt;
    res_r         <= res_nxt;
    req_r         <= req_nxt;
    need_r        <= need_nxt;
    idx_r         <= idx_nxt;
    ptr_r         <= ptr_nxt;
    end_r         <= end_nxt;
    start_r       <= start_nxt;
    len_r         <= len_nxt;
    chk_vld_r     <= chk_vld_nxt;
    chk_idx_r     <= chk_idx_nxt;
    pend_status_r <= pend_status_nxt;
    pend_grant_r  <= pend_grant_nxt;
    out_grant_r   <= out_grant_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Status to the controller.
  always_comb begin
    stat.active       = active_r;
    stat.req          = req_r;
    stat.out_of_range = (SUM_W'(idx_r) >= SUM_W'(managed_r));
    stat.scan_hit     = hit_raw;
    stat.scan_miss    = !chk_vld_r && !issue;
    stat.ptr_done     = (ptr_r >= end_r);
    stat.init_last    = init_last;
  end

  assign out_granted_frame = out_grant_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire
